### src/mic_pkg.sv
package mic_pkg;

  localparam int unsigned ElemW = 32;
  localparam int unsigned DetW  = 64;
  localparam int unsigned EpsW  = 16;

  typedef enum logic [1:0] {
    CFG_SINGULAR_EPSILON = 2'd0,
    CFG_UNUSED1          = 2'd1,
    CFG_UNUSED2          = 2'd2,
    CFG_UNUSED3          = 2'd3
  } cfg_addr_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_M2A,
    ST_M2B,
    ST_M3,
    ST_DET,
    ST_CHECK,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT,
    ST_SING
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

  // Q16.16 product truncated toward zero, full width
  function automatic logic signed [63:0] qmul(logic signed [33:0] a, logic signed [33:0] b);
    logic signed [67:0] p;
    logic signed [67:0] q;
    begin
      p = a * b;
      if (p < 0) q = -((-p) >>> 16);
      else q = p >>> 16;
      qmul = q[63:0];
    end
  endfunction

  function automatic logic signed [33:0] clamp32(logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) clamp32 = 34'sd2147483647;
      else if (v < -64'sd2147483648) clamp32 = -34'sd2147483648;
      else clamp32 = v[33:0];
    end
  endfunction

endpackage

### src/mic_stream_if.sv
interface mic_stream_if #(parameter int unsigned W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/mic_div.sv
// Restoring divider, one quotient bit per cycle, signed via magnitudes.
module mic_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [63:0]  num,
  input  logic signed [63:0]  den,
  output mic_pkg::div_ctl_t   ctl,
  output logic signed [63:0]  quo
);
  logic [63:0] n_r, n_nxt, d_r, d_nxt, rem_r, rem_nxt, q_r, q_nxt;
  logic        neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [64:0] trial;
  logic [63:0] rsh;

  always_comb begin
    n_nxt = n_r; d_nxt = d_r; rem_nxt = rem_r; q_nxt = q_r;
    neg_nxt = neg_r; busy_nxt = busy_r; done_nxt = 1'b0; cnt_nxt = cnt_r;
    rsh = {rem_r[62:0], n_r[63]};
    trial = {1'b0, rsh} - {1'b0, d_r};
    if (start) begin
      n_nxt = num[63] ? -num : num;
      d_nxt = den[63] ? -den : den;
      neg_nxt = num[63] ^ den[63];
      rem_nxt = '0; q_nxt = '0; cnt_nxt = 7'd64; busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[62:0], 1'b0};
      if (!trial[64]) begin
        rem_nxt = trial[63:0]; q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = rsh; q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    n_r <= n_nxt; d_r <= d_nxt; rem_r <= rem_nxt; q_r <= q_nxt; neg_r <= neg_nxt;
  end

  assign quo = neg_r ? -q_r : q_r;
  assign ctl = '{start: start, busy: busy_r, done: done_r};
endmodule

### src/mic_core.sv
// Sequencer: loads 16 elements, then with one shared multiplier works each 3x3
// minor as three 2x2 minors (two products each) plus three products; then the
// determinant and one divide per result, or a single singular result if det is 0 or |det| < eps.
module mic_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] eps,
  mic_stream_if.sink  in_ch,
  mic_stream_if.source out_ch
);
  mic_pkg::state_t state_r, state_nxt;
  logic signed [31:0] m_r [16];
  logic [4:0]  ld_r;
  logic [3:0]  cf_r;       // cofactor index r*4+c
  logic [1:0]  sub_r;      // 2x2 minor / 3x3 term index
  logic        ph_r;       // product phase in a 2x2 minor
  logic signed [63:0] acc_r, det_r;
  logic signed [33:0] m2_r [3];
  logic signed [33:0] cof_r [16];
  logic [3:0]  oi_r;
  logic        ovalid_r;
  logic [34:0] odata_r;
  logic        dstart;
  logic        emit_go;
  logic signed [63:0] quo;
  mic_pkg::div_ctl_t dctl;

  // submatrix helpers
  logic [1:0] dr, dc, rr [3], cc [3];
  logic signed [33:0] ma, mb, prod_a, prod_b;
  logic signed [63:0] prod;
  logic [1:0] i1, i2, j1, j2;

  always_comb begin
    dr = cf_r[3:2]; dc = cf_r[1:0];
    for (int k = 0; k < 3; k++) begin
      rr[k] = (2'(k) >= dr) ? 2'(k + 1) : 2'(k);
      cc[k] = (2'(k) >= dc) ? 2'(k + 1) : 2'(k);
    end
    // 2x2 minor sub_r excludes column sub_r of rows 1,2
    j1 = (sub_r == 2'd0) ? 2'd1 : 2'd0;
    j2 = (sub_r == 2'd2) ? 2'd1 : 2'd2;
    i1 = 2'd1; i2 = 2'd2;
    prod_a = '0; prod_b = '0;
    if (state_r == mic_pkg::ST_M2A || state_r == mic_pkg::ST_M2B) begin
      if (!ph_r) begin
        prod_a = 34'(m_r[{rr[i1], cc[j1]}]); prod_b = 34'(m_r[{rr[i2], cc[j2]}]);
      end else begin
        prod_a = 34'(m_r[{rr[i1], cc[j2]}]); prod_b = 34'(m_r[{rr[i2], cc[j1]}]);
      end
    end else if (state_r == mic_pkg::ST_M3) begin
      prod_a = 34'(m_r[{rr[0], cc[sub_r]}]); prod_b = m2_r[sub_r];
    end else begin
      prod_a = 34'(m_r[{2'd0, sub_r}]); prod_b = cof_r[{2'd0, sub_r}];
    end
    ma = prod_a; mb = prod_b;
  end
  assign prod = mic_pkg::qmul(ma, mb);

  logic signed [63:0] mag;
  assign mag = det_r[63] ? -det_r : det_r;
  assign dstart = (state_r == mic_pkg::ST_DIV_START);
  assign emit_go = (state_r == mic_pkg::ST_EMIT || state_r == mic_pkg::ST_SING) &&
                   (!ovalid_r || out_ch.ready);

  mic_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart),
    .num(64'(cof_r[{oi_r[1:0], oi_r[3:2]}]) <<< 16), .den(det_r),
    .ctl(dctl), .quo(quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mic_pkg::ST_LOAD:
        if (in_ch.valid && in_ch.ready && ld_r == 5'd15) state_nxt = mic_pkg::ST_M2A;
      mic_pkg::ST_M2A: if (ph_r) state_nxt = mic_pkg::ST_M2B;
      mic_pkg::ST_M2B: if (ph_r && sub_r == 2'd2) state_nxt = mic_pkg::ST_M3;
      mic_pkg::ST_M3:
        if (sub_r == 2'd2) state_nxt = (cf_r == 4'd15) ? mic_pkg::ST_DET : mic_pkg::ST_M2A;
      mic_pkg::ST_DET: if (sub_r == 2'd3) state_nxt = mic_pkg::ST_CHECK;
      mic_pkg::ST_CHECK:
        state_nxt = (det_r == 0 || mag < 64'(eps)) ? mic_pkg::ST_SING : mic_pkg::ST_DIV_START;
      mic_pkg::ST_DIV_START: state_nxt = mic_pkg::ST_DIV_WAIT;
      mic_pkg::ST_DIV_WAIT: if (dctl.done) state_nxt = mic_pkg::ST_EMIT;
      mic_pkg::ST_EMIT:
        if (!ovalid_r || out_ch.ready)
          state_nxt = (oi_r == 4'd15) ? mic_pkg::ST_LOAD : mic_pkg::ST_DIV_START;
      mic_pkg::ST_SING:
        if (!ovalid_r || out_ch.ready) state_nxt = mic_pkg::ST_LOAD;
      default: state_nxt = mic_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == mic_pkg::ST_LOAD) && !ovalid_r;
    out_ch.valid = ovalid_r;
    out_ch.data = odata_r;
  end

  logic signed [63:0] m3sum;
  logic signed [33:0] m3c;
  assign m3sum = (sub_r == 2'd1) ? acc_r - prod : acc_r + prod;
  assign m3c = mic_pkg::clamp32(m3sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mic_pkg::ST_LOAD; ld_r <= '0; ovalid_r <= 1'b0;
      cf_r <= '0; sub_r <= '0; ph_r <= 1'b0; oi_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit_go) ovalid_r <= 1'b1;
      else if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        mic_pkg::ST_LOAD:
          if (in_ch.valid && in_ch.ready) begin
            m_r[ld_r[3:0]] <= in_ch.data[31:0];
            ld_r <= (ld_r == 5'd15) ? 5'd0 : ld_r + 5'd1;
            cf_r <= '0; sub_r <= '0; ph_r <= 1'b0;
          end
        mic_pkg::ST_M2A, mic_pkg::ST_M2B: begin
          if (!ph_r) acc_r <= prod;
          else begin
            m2_r[sub_r] <= mic_pkg::clamp32(acc_r - prod);
            sub_r <= (sub_r == 2'd2) ? 2'd0 : sub_r + 2'd1;
          end
          ph_r <= ~ph_r;
        end
        mic_pkg::ST_M3: begin
          if (sub_r == 2'd0) acc_r <= prod;
          else acc_r <= m3sum;
          if (sub_r == 2'd2) begin
            cof_r[cf_r] <= (cf_r[2] ^ cf_r[0]) ? -m3c : m3c;
            cf_r <= cf_r + 4'd1;
            sub_r <= '0;
          end else sub_r <= sub_r + 2'd1;
          if (cf_r == 4'd15 && sub_r == 2'd2) det_r <= '0;
        end
        mic_pkg::ST_DET: begin
          det_r <= det_r + prod;
          sub_r <= sub_r + 2'd1;
          oi_r <= '0;
        end
        mic_pkg::ST_EMIT:
          if (!ovalid_r || out_ch.ready) begin
            odata_r[31:0] <= 32'(mic_pkg::clamp32(quo));
            odata_r[32] <= 1'b0;
            odata_r[33] <= (quo > 64'sd2147483647) || (quo < -64'sd2147483648);
            odata_r[34] <= (oi_r == 4'd15);
            oi_r <= oi_r + 4'd1;
          end
        mic_pkg::ST_SING:
          if (!ovalid_r || out_ch.ready) begin
            odata_r <= {1'b1, 1'b0, 1'b1, 32'd0};
          end
        default: ;
      endcase
    end
  end
endmodule

### src/mat4_inverse_cofactor.sv
// Steps: load 16 elements, then cofactor work for all 16 cofactors on one shared multiplier,
// then the determinant from four products, then one compare against singular_epsilon.
// Each result goes through a divider start, the 64-step divider and an emit.
// One item at a time; input not ready until the last result is taken.
// Synchronous active-low reset clears control; singular_epsilon resets to 1.
module mat4_inverse_cofactor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] in_element_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_result_value,
  output logic        out_singular,
  output logic        out_saturated,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [15:0] eps_r;
  mic_stream_if #(.W(32)) in_if ();
  mic_stream_if #(.W(35)) out_if ();

  assign in_if.valid = in_valid;
  assign in_if.data = in_element_value;
  assign in_ready = in_if.ready;
  assign out_valid = out_if.valid;
  assign out_if.ready = out_ready;
  assign out_result_value = out_if.data[31:0];
  assign out_singular = out_if.data[32];
  assign out_saturated = out_if.data[33];
  assign out_last = out_if.data[34];

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) eps_r <= 16'd1;
    else if (cfg_psel && cfg_penable && cfg_pwrite &&
             cfg_paddr[3:2] == mic_pkg::CFG_SINGULAR_EPSILON && cfg_paddr[1:0] == 2'd0)
      eps_r <= cfg_pwdata[15:0];
  end
  assign cfg_prdata = (cfg_paddr[3:2] == mic_pkg::CFG_SINGULAR_EPSILON) ? {16'd0, eps_r} : 32'd0;

  mic_core u_core (.clk(clk), .rst_n(rst_n), .eps(eps_r), .in_ch(in_if), .out_ch(out_if));
endmodule

### src/mic_checker.sv
module mic_checker (
  input logic clk, input logic rst_n,
  input logic in_ready,
  input logic out_valid, input logic out_ready,
  input logic out_singular, input logic out_saturated, input logic out_last,
  input logic cfg_pready
);
  a_sing_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_last && !out_saturated) else $error("singular not last");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready) else $error("pready low");
endmodule

bind mat4_inverse_cofactor mic_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_singular(out_singular),
  .out_saturated(out_saturated), .out_last(out_last), .cfg_pready(cfg_pready)
);
